>>> hw/rtl/iyu_pkg.sv
// ----------------------------------------------------------------------------
// iyu_pkg
// Shared types, packet positions, register map and the CORDIC arctangent
// table for the yaw unwrap block.
// ----------------------------------------------------------------------------
`default_nettype none

package iyu_pkg;

	// one captured quaternion, handed from the packet parser to the yaw unit
	typedef struct packed {
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
	} iyu_job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SUM,
		B_ROT,
		B_FIN,
		B_OUT
	} iyu_back_state_t;

	localparam int unsigned ATAN_ENTRIES   = 24;
	localparam logic [14:0] POS_LEN_LO     = 15'd0;
	localparam logic [14:0] POS_LEN_HI     = 15'd1;
	localparam logic [14:0] POS_REPORT     = 15'd9;
	localparam logic [14:0] POS_QUAT_FIRST = 15'd13;
	localparam logic [14:0] POS_QUAT_LAST  = 15'd20;
	localparam logic [14:0] POS_MAX        = 15'h7FFF;

	// register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_REPORT_ID = 2'd0;
	localparam logic [1:0] REG_TRACK_EN  = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	localparam logic [7:0]  RESET_REPORT_ID = 8'd40;
	localparam logic [14:0] RESET_THRESHOLD = 15'd31291;

	// atan(2^-i) in 32-bit binary angle units
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/iyu_if.sv
// ----------------------------------------------------------------------------
// iyu channel interfaces
// Valid/ready channels for received bytes and for yaw results.
// ----------------------------------------------------------------------------
`default_nettype none

interface iyu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;
	modport source (output valid, rx_byte, frame_start, input ready);
	modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface iyu_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] raw_yaw;
	logic signed [31:0] total_yaw;
	logic               wrapped;
	modport source (output valid, raw_yaw, total_yaw, wrapped, input ready);
	modport sink   (input valid, raw_yaw, total_yaw, wrapped, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/iyu_front.sv
// ----------------------------------------------------------------------------
// iyu_front
// Packet parser: tracks byte position, captures length, report id and
// quaternion words, and pushes a job when a matching packet ends.
// ----------------------------------------------------------------------------
`default_nettype none

module iyu_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      rx_byte,
	input  wire logic            frame_start,
	input  wire logic [7:0]      report_id,
	input  wire logic            q_full,
	output logic                 q_push,
	output iyu_pkg::iyu_job_t    q_job
);
	import iyu_pkg::*;

	logic [14:0] byte_index_q;
	logic [14:0] len_q;
	logic [7:0]  report_q;
	logic [15:0] words_q [4];
	logic [15:0] words_d [4];
	logic [14:0] pos;
	logic [14:0] off;
	logic        accept;
	logic        done;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pos      = frame_start ? 15'd0 : byte_index_q;
	assign off      = pos - POS_QUAT_FIRST;

	// merge this byte into the word it belongs to
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			words_d[k] = words_q[k];
		end
		if (pos >= POS_QUAT_FIRST && pos <= POS_QUAT_LAST) begin
			if (off[0]) begin
				words_d[off[2:1]][15:8] = rx_byte;
			end else begin
				words_d[off[2:1]][7:0] = rx_byte;
			end
		end
	end

	assign done = (pos >= POS_QUAT_LAST) &&
		({1'b0, pos} + 16'd1 == {1'b0, len_q}) && (report_q == report_id);

	assign q_push   = accept && done;
	assign q_job.qx = words_d[0];
	assign q_job.qy = words_d[1];
	assign q_job.qz = words_d[2];
	assign q_job.qw = words_d[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			len_q        <= '0;
			report_q     <= '0;
		end else if (accept) begin
			byte_index_q <= (pos == POS_MAX) ? pos : pos + 15'd1;
			if (pos == POS_LEN_LO) begin
				len_q <= {7'd0, rx_byte};
			end else if (pos == POS_LEN_HI) begin
				len_q <= {rx_byte[6:0], len_q[7:0]};
			end
			if (pos == POS_REPORT) begin
				report_q <= rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 4; k++) begin
				words_q[k] <= words_d[k];
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/iyu_queue.sv
// ----------------------------------------------------------------------------
// iyu_queue
// Two-entry job queue between the parser and the yaw unit.
// ----------------------------------------------------------------------------
`default_nettype none

module iyu_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire iyu_pkg::iyu_job_t  push_job,
	output logic                    full,
	input  wire logic               pop,
	output logic                    not_empty,
	output iyu_pkg::iyu_job_t       pop_job
);
	import iyu_pkg::*;

	iyu_job_t   ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_job   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");

endmodule

`default_nettype wire

>>> hw/rtl/iyu_back.sv
// ----------------------------------------------------------------------------
// iyu_back
// Yaw unit: forms numerator and denominator with one shared multiplier,
// runs an iterative vectoring CORDIC, unwraps and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module iyu_back #(
	parameter int CORDIC_STEPS   = 16,
	parameter int QUAT_FRAC_BITS = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	input  wire iyu_pkg::iyu_job_t  job,
	output logic                    job_pop,
	input  wire logic               track_en,
	input  wire logic [14:0]        threshold,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      raw_yaw,
	output logic signed [31:0]      total_yaw,
	output logic                    wrapped
);
	import iyu_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);
	localparam int AW = 34;
	localparam int XW = 38;
	localparam logic signed [XW-1:0] ONE = XW'(64'sd1 <<< (2 * QUAT_FRAC_BITS));
	localparam logic [IW-1:0] LAST_IT = IW'(CORDIC_STEPS - 1);

	iyu_back_state_t st_q, st_d;

	iyu_job_t              job_q;
	logic [2:0]            cnt_q;
	logic signed [31:0]    prod_q;
	logic signed [AW-1:0]  accn_q, accd_q;
	logic signed [XW-1:0]  x_q, y_q;
	logic [31:0]           ang_q;
	logic [IW-1:0]         it_q;
	logic                  zero_q;
	logic signed [15:0]    prev_q, raw_q;
	logic signed [31:0]    total_q;
	logic                  wrapped_q;

	logic signed [15:0]    ma, mb;
	logic signed [XW-1:0]  num, den, dx, dy;
	logic [31:0]           atan_v, ang_rnd;
	logic signed [15:0]    raw_v;
	logic signed [17:0]    step, step_abs, step_adj;
	logic                  wrap_v;
	logic signed [33:0]    tsum;
	logic signed [31:0]    tsat;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE: if (job_valid) st_d = B_MUL;
			B_MUL:  if (cnt_q == 3'd4) st_d = B_SUM;
			B_SUM:  st_d = B_ROT;
			B_ROT:  if (it_q == LAST_IT) st_d = B_FIN;
			B_FIN:  st_d = B_OUT;
			B_OUT:  if (out_ready) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		job_pop   = (st_q == B_IDLE) && job_valid;
		out_valid = (st_q == B_OUT);
	end

	// one multiplier: w*z, x*y, y*y, z*z
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin ma = job_q.qw; mb = job_q.qz; end
			2'd1: begin ma = job_q.qx; mb = job_q.qy; end
			2'd2: begin ma = job_q.qy; mb = job_q.qy; end
			default: begin ma = job_q.qz; mb = job_q.qz; end
		endcase
	end

	assign num    = XW'(accn_q) <<< 1;
	assign den    = ONE - (XW'(accd_q) <<< 1);
	assign dx     = y_q >>> it_q;
	assign dy     = x_q >>> it_q;
	assign atan_v = atan_entry(5'(it_q));

	// round to 16 bits and unwrap against the previous yaw
	always_comb begin
		ang_rnd  = ang_q + 32'h00008000;
		raw_v    = zero_q ? 16'sd0 : $signed(ang_rnd[31:16]);
		step     = 18'(raw_v) - 18'(prev_q);
		step_abs = step[17] ? -step : step;
		wrap_v   = track_en && (step_abs >= $signed({3'd0, threshold}));
		step_adj = !track_en ? 18'sd0 :
			!wrap_v ? step :
			raw_v[15] ? step + 18'sd65536 : step - 18'sd65536;
		tsum     = 34'(total_q) + 34'(step_adj);
		if (tsum > 34'sh7FFFFFFF) begin
			tsat = 32'sh7FFFFFFF;
		end else if (tsum < -34'sh80000000) begin
			tsat = -32'sh80000000;
		end else begin
			tsat = tsum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				job_q  <= job;
				accn_q <= '0;
				accd_q <= '0;
			end
			B_MUL: begin
				prod_q <= ma * mb;
				if (cnt_q != 3'd0) begin
					if (cnt_q <= 3'd2) begin
						accn_q <= accn_q + AW'(prod_q);
					end else begin
						accd_q <= accd_q + AW'(prod_q);
					end
				end
			end
			B_SUM: begin
				zero_q <= (num == '0) && (den == '0);
				if (den < 0) begin
					x_q   <= -den;
					y_q   <= -num;
					ang_q <= 32'h80000000;
				end else begin
					x_q   <= den;
					y_q   <= num;
					ang_q <= 32'h0;
				end
			end
			B_ROT: begin
				if (!y_q[XW-1]) begin
					x_q   <= x_q + dx;
					y_q   <= y_q - dy;
					ang_q <= ang_q + atan_v;
				end else begin
					x_q   <= x_q - dx;
					y_q   <= y_q + dy;
					ang_q <= ang_q - atan_v;
				end
			end
			B_FIN: begin
				raw_q     <= raw_v;
				wrapped_q <= wrap_v;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= B_IDLE;
			cnt_q   <= '0;
			it_q    <= '0;
			prev_q  <= '0;
			total_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == B_IDLE) cnt_q <= '0;
			else if (st_q == B_MUL) cnt_q <= cnt_q + 3'd1;
			if (st_q == B_SUM) it_q <= '0;
			else if (st_q == B_ROT) it_q <= it_q + 1'b1;
			if (st_q == B_FIN) begin
				prev_q  <= raw_v;
				total_q <= tsat;
			end
		end
	end

	assign raw_yaw   = raw_q;
	assign total_yaw = total_q;
	assign wrapped   = wrapped_q;

	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> st_q == B_OUT) else $error("result shown outside output state");
	a_rot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_ROT |-> it_q <= LAST_IT) else $error("CORDIC ran past last step");
	a_taken_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_OUT && out_ready) |=> st_q == B_IDLE) else $error("no return to idle");
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> st_q == B_MUL) else $error("job popped but not started");

endmodule

`default_nettype wire

>>> hw/rtl/imu_packet_yaw_unwrap_top.sv
// ----------------------------------------------------------------------------
// imu_packet_yaw_unwrap_top
// Sensor-hub packet parser with quaternion-to-yaw CORDIC and yaw unwrapping.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle while the job queue has room.
// Flow: a matching packet's last byte pushes a job, which the yaw unit pops,
//   multiplies and accumulates, sets up, runs CORDIC_STEPS rotations in the
//   shared rotator, finishes and outputs; the rotator sets the pace.
// Reset: arst_n clears parser position, length, report id, previous yaw,
//   total yaw and the registers to their defaults; quaternion words are unreset.
`default_nettype none

module imu_packet_yaw_unwrap_top #(
	parameter int CORDIC_STEPS   = 16,
	parameter int QUAT_FRAC_BITS = 14
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	iyu_in_if.sink           in_ch,
	iyu_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import iyu_pkg::*;

	logic [7:0]  report_id_q;
	logic        track_en_q;
	logic [14:0] threshold_q;
	logic        cfg_wr;

	logic     q_push, q_full, q_pop, q_not_empty;
	iyu_job_t push_job, pop_job;

	// configuration: write on the access cycle, pready tied high
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_id_q <= RESET_REPORT_ID;
			track_en_q  <= 1'b0;
			threshold_q <= RESET_THRESHOLD;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_REPORT_ID: report_id_q <= pwdata[7:0];
				REG_TRACK_EN:  track_en_q  <= pwdata[0];
				REG_THRESHOLD: threshold_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_REPORT_ID: prdata = {24'd0, report_id_q};
			REG_TRACK_EN:  prdata = {31'd0, track_en_q};
			REG_THRESHOLD: prdata = {17'd0, threshold_q};
			default:       prdata = 32'd0;
		endcase
	end

	// front: parse bytes, push a job per matching packet end
	iyu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.rx_byte     (in_ch.rx_byte),
		.frame_start (in_ch.frame_start),
		.report_id   (report_id_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	// queue: lets the parser keep taking bytes while the yaw unit works
	iyu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_job   (pop_job)
	);

	// back: yaw, unwrap and hold the result until transfer
	iyu_back #(
		.CORDIC_STEPS   (CORDIC_STEPS),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_not_empty),
		.job       (pop_job),
		.job_pop   (q_pop),
		.track_en  (track_en_q),
		.threshold (threshold_q),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.raw_yaw   (out_ch.raw_yaw),
		.total_yaw (out_ch.total_yaw),
		.wrapped   (out_ch.wrapped)
	);

endmodule

`default_nettype wire
